/* design/fpl_pkg.sv */
// fpl_pkg: shared types, codes and constants of the frame pacing limiter
// used by fpl_step and frame_pacing_limiter; no dependencies
`default_nettype none

package fpl_pkg;

	// default parameter values
	localparam int TIME_BITS_DEF     = 48;
	localparam int INTERVAL_BITS_DEF = 24;

	// fixed field widths
	localparam int DEV_W     = 26;
	localparam int WAIT_W    = 26;
	localparam int CFG_IDX_W = 2;

	// time differences saturate at 2^DIFF_LIM_LOG ticks
	localparam int DIFF_LIM_LOG = 40;
	// signed working width of the frame arithmetic (holds 100 * 2^40 with sign)
	localparam int CALC_W = 50;

	// slow frame test: 100 * frame time > 103 * interval - 100 * deviation
	localparam int SLOW_NUM = 103;
	localparam int SLOW_DEN = 100;
	// deviation is capped at interval / 16
	localparam int DEV_CAP_SHIFT = 4;

	// command codes
	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_WAKE  = 1'b1;

	// method codes; any other code runs the plain timeline
	localparam logic [1:0] METHOD_DEVIATION = 2'd0;
	localparam logic [1:0] METHOD_REACTIVE  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOFT_LIMIT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_METHOD          = 2'd2;

	// control part of the pacing state
	typedef struct packed {
		logic signed [DEV_W-1:0] dev;
		logic                    has_deadline;
		logic                    wake_pending;
	} ctl_state_t;

	// status flags of one result beat
	typedef struct packed {
		logic awaiting_wake;
		logic slow_frame;
		logic protocol_error;
	} flags_t;

endpackage

`default_nettype wire

/* design/fpl_step.sv */
// fpl_step: combinational update of the pacing state for one item
// depends on fpl_pkg (widths, codes, state and flag structs)
`default_nettype none

module fpl_step #(
	parameter int TIME_BITS     = fpl_pkg::TIME_BITS_DEF,
	parameter int INTERVAL_BITS = fpl_pkg::INTERVAL_BITS_DEF
) (
	input  wire logic                          cmd,
	input  wire logic [TIME_BITS-1:0]          now,
	input  wire logic [INTERVAL_BITS-1:0]      target_interval,
	input  wire logic                          soft_limit,
	input  wire logic [1:0]                    method,
	input  wire logic [TIME_BITS-1:0]          last_frame_time,
	input  wire logic [TIME_BITS-1:0]          next_deadline,
	input  wire logic [INTERVAL_BITS-1:0]      interval_of_last,
	input  wire fpl_pkg::ctl_state_t           ctl,
	output logic      [TIME_BITS-1:0]          last_frame_time_nxt,
	output logic      [TIME_BITS-1:0]          next_deadline_nxt,
	output logic      [INTERVAL_BITS-1:0]      interval_of_last_nxt,
	output fpl_pkg::ctl_state_t                ctl_nxt,
	output logic      [fpl_pkg::WAIT_W-1:0]    wait_ticks,
	output fpl_pkg::flags_t                    flags
);

	localparam int AW    = fpl_pkg::CALC_W;
	localparam int DW    = fpl_pkg::DEV_W;
	localparam int EW    = (TIME_BITS > 41) ? TIME_BITS + 1 : 42;
	localparam logic [EW-1:0] LIM_E = EW'(1) << fpl_pkg::DIFF_LIM_LOG;
	localparam logic signed [AW-1:0] LIM_A    = AW'(1) << fpl_pkg::DIFF_LIM_LOG;
	localparam logic signed [AW-1:0] K_DEN    = AW'(fpl_pkg::SLOW_DEN);
	localparam logic signed [AW-1:0] K_NUM    = AW'(fpl_pkg::SLOW_NUM);
	localparam logic signed [AW-1:0] DEV_MAX  = AW'(2 ** (DW - 1) - 1);
	localparam logic signed [AW-1:0] DEV_MIN  = -(AW'(2 ** (DW - 1)));
	localparam logic signed [AW-1:0] WAIT_MAX = AW'(2 ** fpl_pkg::WAIT_W - 1);

	logic        [TIME_BITS-1:0] d_ft;
	logic        [EW-1:0]        ft_e;
	logic        [EW-1:0]        ft_lim_e;
	logic signed [AW-1:0]        ft;
	logic        [TIME_BITS-1:0] d_dl;
	logic        [TIME_BITS-1:0] d_dl_neg;
	logic        [EW-1:0]        mag_e;
	logic signed [AW-1:0]        mag;
	logic signed [AW-1:0]        over;
	logic signed [AW-1:0]        iv;
	logic signed [AW-1:0]        dev;
	logic signed [AW-1:0]        slow_lhs;
	logic signed [AW-1:0]        slow_rhs;
	logic                        is_slow;
	logic signed [AW-1:0]        spare;
	logic signed [AW-1:0]        fin_d;
	logic signed [AW-1:0]        cap;
	logic signed [AW-1:0]        fin_c;
	logic signed [AW-1:0]        fin_s;
	logic signed [DW-1:0]        dev_fin;
	logic                        restart;
	logic signed [AW-1:0]        remaining;
	logic signed [AW-1:0]        wait_arg;
	logic                        iv_zero;

	// elapsed frame time, unsigned and saturated
	assign d_ft     = now - last_frame_time;
	assign ft_e     = {{(EW - TIME_BITS){1'b0}}, d_ft};
	assign ft_lim_e = (ft_e > LIM_E) ? LIM_E : ft_e;
	assign ft       = signed'(AW'(ft_lim_e));

	// signed distance past the cadence deadline, saturated
	assign d_dl     = now - next_deadline;
	assign d_dl_neg = -d_dl;
	assign mag_e    = {{(EW - TIME_BITS){1'b0}},
		d_dl[TIME_BITS-1] ? d_dl_neg : d_dl};
	assign mag      = (mag_e > LIM_E) ? LIM_A : signed'(AW'(mag_e));
	assign over     = d_dl[TIME_BITS-1] ? -mag : mag;

	// operands in the working width
	assign iv      = signed'(AW'(target_interval));
	assign dev     = {{(AW - DW){ctl.dev[DW-1]}}, ctl.dev};
	assign iv_zero = (target_interval == '0);

	// slow frame decision and time left in deviation mode
	assign slow_lhs = ft * K_DEN;
	assign slow_rhs = iv * K_NUM - dev * K_DEN;
	assign is_slow  = slow_lhs > slow_rhs;
	assign spare    = iv - dev - ft;

	// deviation after a frame ends at now: add overshoot, cap, saturate
	assign fin_d   = dev + ft - iv;
	assign cap     = iv >>> fpl_pkg::DEV_CAP_SHIFT;
	assign fin_c   = (fin_d > cap) ? cap : fin_d;
	assign fin_s   = (fin_c > DEV_MAX) ? DEV_MAX : ((fin_c < DEV_MIN) ? DEV_MIN : fin_c);
	assign dev_fin = fin_s[DW-1:0];

	// timeline: cadence restart or time left to the next slot
	assign restart = !ctl.has_deadline || (interval_of_last != target_interval) ||
		(method == fpl_pkg::METHOD_REACTIVE);
	assign remaining = (restart || over >= iv) ? iv : iv - over;

	// state update and result selection
	always_comb begin
		last_frame_time_nxt  = last_frame_time;
		next_deadline_nxt    = next_deadline;
		interval_of_last_nxt = interval_of_last;
		ctl_nxt              = ctl;
		wait_arg             = '0;
		flags.slow_frame     = 1'b0;
		flags.protocol_error = 1'b0;
		if (cmd == fpl_pkg::CMD_WAKE) begin
			if (!ctl.wake_pending) begin
				flags.protocol_error = 1'b1;
			end else begin
				ctl_nxt.wake_pending = 1'b0;
				last_frame_time_nxt  = now;
				if (method == fpl_pkg::METHOD_DEVIATION) begin
					ctl_nxt.dev = dev_fin;
				end else begin
					next_deadline_nxt    = now;
					ctl_nxt.has_deadline = 1'b1;
				end
			end
		end else if (ctl.wake_pending) begin
			flags.protocol_error = 1'b1;
		end else if (!iv_zero) begin
			if (method == fpl_pkg::METHOD_DEVIATION) begin
				if (is_slow) begin
					flags.slow_frame    = 1'b1;
					last_frame_time_nxt = now;
					if (!soft_limit) begin
						ctl_nxt.dev = '0;
					end
				end else if (spare > 0) begin
					wait_arg             = spare;
					ctl_nxt.wake_pending = 1'b1;
				end else begin
					ctl_nxt.dev         = dev_fin;
					last_frame_time_nxt = now;
				end
			end else begin
				interval_of_last_nxt = target_interval;
				wait_arg             = remaining;
				ctl_nxt.wake_pending = 1'b1;
			end
		end
		flags.awaiting_wake = ctl_nxt.wake_pending;
	end

	// wait saturates to its field range
	always_comb begin
		if (wait_arg <= 0) begin
			wait_ticks = '0;
		end else if (wait_arg > WAIT_MAX) begin
			wait_ticks = WAIT_MAX[fpl_pkg::WAIT_W-1:0];
		end else begin
			wait_ticks = wait_arg[fpl_pkg::WAIT_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* design/frame_pacing_limiter.sv */
// frame_pacing_limiter: input register, combinational state update in fpl_step, result register;
// the result beat is offered once the item advances from the input register to the result register
// throughput is one item per cycle while out_ready does not stall the result register
// reset clears configuration, pacing state and both handshake stages at once
// depends on fpl_pkg and fpl_step
`default_nettype none

module frame_pacing_limiter #(
	parameter int TIME_BITS     = fpl_pkg::TIME_BITS_DEF,
	parameter int INTERVAL_BITS = fpl_pkg::INTERVAL_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [fpl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [INTERVAL_BITS-1:0]          cfg_data,
	// input items
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              cmd,
	input  wire logic [TIME_BITS-1:0]              now,
	// result items
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [fpl_pkg::WAIT_W-1:0]        wait_ticks,
	output logic                                   awaiting_wake,
	output logic                                   slow_frame,
	output logic                                   protocol_error,
	output logic signed [fpl_pkg::DEV_W-1:0]       deviation_now
);

	logic [INTERVAL_BITS-1:0] target_interval_q;
	logic                     soft_limit_q;
	logic [1:0]               method_q;

	logic                     valid_s1;
	logic                     cmd_s1;
	logic [TIME_BITS-1:0]     now_s1;
	logic                     advance;

	logic [TIME_BITS-1:0]     last_frame_time_q;
	logic [TIME_BITS-1:0]     next_deadline_q;
	logic [INTERVAL_BITS-1:0] interval_of_last_q;
	fpl_pkg::ctl_state_t      ctl_q;

	logic [TIME_BITS-1:0]     last_frame_time_nxt;
	logic [TIME_BITS-1:0]     next_deadline_nxt;
	logic [INTERVAL_BITS-1:0] interval_of_last_nxt;
	fpl_pkg::ctl_state_t      ctl_nxt;
	logic [fpl_pkg::WAIT_W-1:0] wait_nxt;
	fpl_pkg::flags_t          flags_nxt;

	logic                     out_valid_q;
	logic [fpl_pkg::WAIT_W-1:0] wait_q;
	fpl_pkg::flags_t          flags_q;
	logic signed [fpl_pkg::DEV_W-1:0] dev_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_interval_q <= '0;
			soft_limit_q      <= 1'b0;
			method_q          <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fpl_pkg::REG_TARGET_INTERVAL: target_interval_q <= cfg_data;
				fpl_pkg::REG_SOFT_LIMIT:      soft_limit_q      <= cfg_data[0];
				fpl_pkg::REG_METHOD:          method_q          <= cfg_data[1:0];
				default:                      ;
			endcase
		end
	end

	// stage handshake: the input stage moves on whenever the result register frees
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			now_s1 <= now;
		end
	end

	// state update for the item in the input register
	fpl_step #(
		.TIME_BITS     (TIME_BITS),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_step (
		.cmd                  (cmd_s1),
		.now                  (now_s1),
		.target_interval      (target_interval_q),
		.soft_limit           (soft_limit_q),
		.method               (method_q),
		.last_frame_time      (last_frame_time_q),
		.next_deadline        (next_deadline_q),
		.interval_of_last     (interval_of_last_q),
		.ctl                  (ctl_q),
		.last_frame_time_nxt  (last_frame_time_nxt),
		.next_deadline_nxt    (next_deadline_nxt),
		.interval_of_last_nxt (interval_of_last_nxt),
		.ctl_nxt              (ctl_nxt),
		.wait_ticks           (wait_nxt),
		.flags                (flags_nxt)
	);

	// pacing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_frame_time_q  <= '0;
			next_deadline_q    <= '0;
			interval_of_last_q <= '0;
			ctl_q              <= '0;
		end else if (advance) begin
			last_frame_time_q  <= last_frame_time_nxt;
			next_deadline_q    <= next_deadline_nxt;
			interval_of_last_q <= interval_of_last_nxt;
			ctl_q              <= ctl_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wait_q  <= wait_nxt;
			flags_q <= flags_nxt;
			dev_q   <= ctl_nxt.dev;
		end
	end

	assign out_valid      = out_valid_q;
	assign wait_ticks     = wait_q;
	assign awaiting_wake  = flags_q.awaiting_wake;
	assign slow_frame     = flags_q.slow_frame;
	assign protocol_error = flags_q.protocol_error;
	assign deviation_now  = dev_q;

	// a slow frame is released at once and expects no wake
	a_slow_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slow_frame |-> wait_ticks == '0 && !awaiting_wake)
		else $error("slow frame beat carries a wait");

	// an ignored item neither waits nor judges the frame
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && protocol_error |-> wait_ticks == '0 && !slow_frame)
		else $error("ignored item produced a wait or slow flag");

	// any wait leaves the block expecting a wake report
	a_wait_wake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wait_ticks != '0 |-> awaiting_wake)
		else $error("wait issued without expecting a wake");

	// a matching wake report always ends the pending wait
	a_wake_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 == fpl_pkg::CMD_WAKE && ctl_q.wake_pending
		|=> !ctl_q.wake_pending && !flags_q.awaiting_wake)
		else $error("wake report left the wait pending");

endmodule

`default_nettype wire

/* sim/frame_pacing_checker.sv */
// frame_pacing_checker: watches the register, frame and result channels of the limiter,
// keeps its own pacing state and compares every result beat with its prediction
// depends on fpl_pkg
`timescale 1ns / 100ps

module frame_pacing_checker import fpl_pkg::*; (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]            cfg_index,
	input  wire logic [INTERVAL_BITS_DEF-1:0]    cfg_data,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire logic                            cmd,
	input  wire logic [TIME_BITS_DEF-1:0]        now,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic [WAIT_W-1:0]               wait_ticks,
	input  wire logic                            awaiting_wake,
	input  wire logic                            slow_frame,
	input  wire logic                            protocol_error,
	input  wire logic signed [DEV_W-1:0]         deviation_now,
	output int                                   fail_count,
	output int                                   results_owed,
	output int                                   checked_count,
	output int                                   slow_count,
	output int                                   error_count,
	output logic                                 wake_owed,
	output logic [WAIT_W-1:0]                    wake_wait
);

	localparam int TW = TIME_BITS_DEF;
	localparam int IW = INTERVAL_BITS_DEF;
	localparam longint DIFF_CAP = longint'(1) << DIFF_LIM_LOG;
	localparam longint DEV_HI = (longint'(1) << (DEV_W - 1)) - 1;
	localparam longint DEV_LO = -(longint'(1) << (DEV_W - 1));
	localparam longint WAIT_HI = (longint'(1) << WAIT_W) - 1;
	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		logic [WAIT_W-1:0]       wait_ticks;
		logic                    awaiting_wake;
		logic                    slow_frame;
		logic                    protocol_error;
		logic signed [DEV_W-1:0] deviation_now;
	} pace_beat_t;

	// register copies
	logic [IW-1:0] cfg_interval;
	logic          cfg_soft;
	logic [1:0]    cfg_method;

	// pacing state
	logic [TW-1:0] release_time;
	logic [TW-1:0] cadence_deadline;
	longint        dev_acc;
	logic          deadline_valid;
	logic [IW-1:0] interval_seen;
	logic          wake_due;
	logic [WAIT_W-1:0] due_wait;

	pace_beat_t owed_results[$];
	int fail_total, compared, slow_total, error_total;

	// unsigned elapsed time, saturated
	function automatic longint elapsed(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW-1:0] d;
		d = a - b;
		if (d > DIFF_CAP) return DIFF_CAP;
		return longint'(d);
	endfunction

	// signed cadence offset, saturated both ways
	function automatic longint cadence_offset(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW-1:0] d;
		logic [TW-1:0] n;
		d = a - b;
		if (d[TW-1]) begin
			n = -d;
			if (n > DIFF_CAP) return -DIFF_CAP;
			return -longint'(n);
		end
		if (d > DIFF_CAP) return DIFF_CAP;
		return longint'(d);
	endfunction

	function automatic longint clamp_dev(input longint v);
		if (v > DEV_HI) return DEV_HI;
		if (v < DEV_LO) return DEV_LO;
		return v;
	endfunction

	function automatic logic [WAIT_W-1:0] clamp_wait(input longint v);
		if (v <= 0) return '0;
		if (v > WAIT_HI) return '1;
		return v[WAIT_W-1:0];
	endfunction

	// fold a finished fast frame into the deviation, capped at interval/16
	function automatic void close_frame(input logic [TW-1:0] t1);
		longint iv;
		longint d;
		iv = longint'(cfg_interval);
		d = dev_acc + elapsed(t1, release_time) - iv;
		if (d > (iv >>> DEV_CAP_SHIFT)) d = iv >>> DEV_CAP_SHIFT;
		dev_acc = clamp_dev(d);
		release_time = t1;
	endfunction

	// pacing decision for one frame or wake beat, updates the state copy
	function automatic pace_beat_t pacing_decision(input logic c, input logic [TW-1:0] t);
		pace_beat_t r;
		longint iv;
		longint ft;
		longint slack;
		longint over;
		longint remaining;
		logic restart;
		iv = longint'(cfg_interval);
		r = '0;
		if (c == CMD_WAKE) begin
			if (!wake_due) begin
				r.protocol_error = 1'b1;
			end else begin
				wake_due = 1'b0;
				if (cfg_method == METHOD_DEVIATION) begin
					close_frame(t);
				end else begin
					cadence_deadline = t;
					deadline_valid = 1'b1;
					release_time = t;
				end
			end
		end else if (wake_due) begin
			r.protocol_error = 1'b1;
		end else if (iv != 0) begin
			if (cfg_method == METHOD_DEVIATION) begin
				ft = elapsed(t, release_time);
				if (ft * SLOW_DEN > iv * SLOW_NUM - dev_acc * SLOW_DEN) begin
					r.slow_frame = 1'b1;
					if (!cfg_soft) dev_acc = 0;
					release_time = t;
				end else begin
					slack = iv - dev_acc - ft;
					if (slack > 0) begin
						r.wait_ticks = clamp_wait(slack);
						wake_due = 1'b1;
						due_wait = r.wait_ticks;
					end else begin
						close_frame(t);
					end
				end
			end else begin
				restart = !deadline_valid || interval_seen != cfg_interval ||
					cfg_method == METHOD_REACTIVE;
				interval_seen = cfg_interval;
				if (restart) begin
					remaining = iv;
				end else begin
					over = cadence_offset(t, cadence_deadline);
					remaining = (over >= iv) ? iv : iv - over;
				end
				r.wait_ticks = clamp_wait(remaining);
				wake_due = 1'b1;
				due_wait = r.wait_ticks;
			end
		end
		r.awaiting_wake = wake_due;
		r.deviation_now = dev_acc[DEV_W-1:0];
		return r;
	endfunction

	// result beats are matched before new frame beats are predicted
	always @(posedge clk or negedge arst_n) begin
		pace_beat_t got;
		pace_beat_t want;
		if (!arst_n) begin
			cfg_interval = '0;
			cfg_soft = 1'b0;
			cfg_method = METHOD_DEVIATION;
			release_time = '0;
			cadence_deadline = '0;
			dev_acc = 0;
			deadline_valid = 1'b0;
			interval_seen = '0;
			wake_due = 1'b0;
			due_wait = '0;
			owed_results.delete();
			fail_total = 0;
			compared = 0;
			slow_total = 0;
			error_total = 0;
		end else begin
			// result channel
			if (out_valid && out_ready) begin
				got = '{wait_ticks, awaiting_wake, slow_frame, protocol_error, deviation_now};
				if (owed_results.size() == 0) begin
					if (fail_total < SHOW_LIMIT)
						$display("unexpected result: wait %0d awaiting %0b slow %0b error %0b dev %0d",
							got.wait_ticks, got.awaiting_wake, got.slow_frame,
							got.protocol_error, got.deviation_now);
					fail_total++;
				end else begin
					want = owed_results.pop_front();
					if (got !== want) begin
						if (fail_total < SHOW_LIMIT) begin
							$write("result %0d mismatch (expected/actual): wait %0d/%0d ",
								compared, want.wait_ticks, got.wait_ticks);
							$display("awaiting %0b/%0b slow %0b/%0b error %0b/%0b dev %0d/%0d",
								want.awaiting_wake, got.awaiting_wake,
								want.slow_frame, got.slow_frame,
								want.protocol_error, got.protocol_error,
								want.deviation_now, got.deviation_now);
						end
						fail_total++;
					end
					compared++;
				end
			end
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TARGET_INTERVAL: cfg_interval = cfg_data;
					REG_SOFT_LIMIT:      cfg_soft = cfg_data[0];
					REG_METHOD:          cfg_method = cfg_data[1:0];
					default: ;
				endcase
			end
			// frame and wake beats
			if (in_valid && in_ready) begin
				want = pacing_decision(cmd, now);
				owed_results.push_back(want);
				if (want.slow_frame) slow_total++;
				if (want.protocol_error) error_total++;
			end
		end
		fail_count = fail_total;
		results_owed = owed_results.size();
		checked_count = compared;
		slow_count = slow_total;
		error_count = error_total;
		wake_owed = wake_due;
		wake_wait = due_wait;
	end

endmodule

/* sim/frame_pacing_limiter_tb.sv */
// frame_pacing_limiter_tb: clock, reset, frame and wake stimulus and the verdict
// for the frame pacing limiter; depends on fpl_pkg, frame_pacing_limiter and frame_pacing_checker
`timescale 1ns / 100ps

module frame_pacing_limiter_tb;
	import fpl_pkg::*;

	localparam int TW = TIME_BITS_DEF;
	localparam int IW = INTERVAL_BITS_DEF;
	localparam logic [1:0] METHOD_TIMELINE = 2'd1;
	localparam logic [1:0] METHOD_ALIAS    = 2'd3;
	localparam logic [IW-1:0] IV_MAX = '1;
	localparam logic [TW-1:0] JUMP_FWD  = TW'(1) << 45;
	localparam logic [TW-1:0] JUMP_BACK = TW'(1) << 44;
	localparam int PHASES = 13;
	localparam int PHASE_ITEMS = 31;
	localparam int TAIL_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [IW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_FRAME;
	logic [TW-1:0] now = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [WAIT_W-1:0] wait_ticks;
	logic awaiting_wake;
	logic slow_frame;
	logic protocol_error;
	logic signed [DEV_W-1:0] deviation_now;

	int fail_count;
	int results_owed;
	int checked_count;
	int slow_count;
	int error_count;
	logic wake_owed;
	logic [WAIT_W-1:0] wake_wait;

	logic free_run = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	int writes_done = 0;

	frame_pacing_limiter u_top (.*);

	frame_pacing_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		if (free_run) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// result side back-pressure
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 2) == 0) stall_left = gap_len();
			out_ready <= (stall_left == 0);
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// one frame or wake beat, valid held until taken
	task automatic send_item(input logic c, input logic [TW-1:0] t);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		now <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// stop sending and wait for every owed result
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_owed != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IW-1:0] data);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		writes_done++;
	endtask

	initial begin
		logic [TW-1:0] t;
		logic [63:0] wide;
		logic [IW-1:0] iv;
		logic [1:0] meth;
		logic c;
		int unsigned scale;
		int phase;
		int k;
		int r;

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// disabled block and a stray wake right after reset
		send_item(CMD_FRAME, '0);
		send_item(CMD_WAKE, '1);
		write_reg(REG_TARGET_INTERVAL, 1000);
		write_reg(REG_SOFT_LIMIT, 0);
		write_reg(REG_METHOD, METHOD_DEVIATION);
		// fast frame, frame start while the wake is owed, late wake
		send_item(CMD_FRAME, 500);
		send_item(CMD_FRAME, 600);
		send_item(CMD_WAKE, 1100);
		// slow frame clears the deviation, a frame just past the interval goes at once
		send_item(CMD_FRAME, 6100);
		send_item(CMD_FRAME, 7110);
		// soft limit keeps the deviation across a slow frame
		write_reg(REG_SOFT_LIMIT, 1);
		send_item(CMD_FRAME, 7210);
		send_item(CMD_WAKE, 7212);
		send_item(CMD_FRAME, 16212);
		// early wakes at the largest interval drive the deviation to its floor
		write_reg(REG_TARGET_INTERVAL, IV_MAX);
		t = 16212;
		repeat (2) begin
			t = t + 1;
			send_item(CMD_FRAME, t);
			t = t + 1;
			send_item(CMD_WAKE, t);
		end
		// timeline: fresh cadence, late frame, overrun, timestamp behind the deadline
		write_reg(REG_METHOD, METHOD_TIMELINE);
		t = t + 10;
		send_item(CMD_FRAME, t);
		t = t + IV_MAX + 50;
		send_item(CMD_WAKE, t);
		t = t + 100;
		send_item(CMD_FRAME, t);
		t = t + IV_MAX;
		send_item(CMD_WAKE, t);
		send_item(CMD_FRAME, t + JUMP_FWD);
		t = t + JUMP_FWD + IV_MAX;
		send_item(CMD_WAKE, t);
		send_item(CMD_FRAME, t - JUMP_BACK);
		t = t + 5;
		send_item(CMD_WAKE, t);
		// reactive mode restarts the cadence every frame
		write_reg(REG_METHOD, METHOD_REACTIVE);
		t = t + 300;
		send_item(CMD_FRAME, t);
		t = t + IV_MAX;
		send_item(CMD_WAKE, t);
		// code three runs the plain timeline; interval cleared while the wake is owed
		write_reg(REG_METHOD, METHOD_ALIAS);
		t = t + 40;
		send_item(CMD_FRAME, t);
		write_reg(REG_TARGET_INTERVAL, 0);
		t = t + IV_MAX;
		send_item(CMD_WAKE, t);
		t = t + 7;
		send_item(CMD_FRAME, t);

		// random phases, one register setting each
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: iv = IV_MAX;
				1: iv = 1;
				2: iv = '0;
				default: begin
					r = $urandom_range(0, 9);
					case (r)
						0: iv = '0;
						1: iv = IV_MAX;
						2: iv = 1;
						3: iv = $urandom_range(2, 64);
						4, 5, 6: iv = $urandom_range(1000, 400000);
						7: iv = $urandom_range(0, 32'hFF_FFFF);
						default: iv = $urandom_range(100000, 200000);
					endcase
				end
			endcase
			case (phase)
				0: meth = METHOD_DEVIATION;
				1: meth = METHOD_TIMELINE;
				3: meth = METHOD_REACTIVE;
				default: meth = ($urandom_range(0, 9) == 0) ? METHOD_ALIAS :
					2'($urandom_range(0, 2));
			endcase
			write_reg(REG_TARGET_INTERVAL, iv);
			write_reg(REG_SOFT_LIMIT, IW'($urandom_range(0, 1)));
			write_reg(REG_METHOD, meth);
			free_run = (phase == 4) || ($urandom_range(0, 3) == 0);
			scale = (iv == 0) ? 1000 : iv;

			// timebase: keep, jump anywhere, or sit just below the wrap
			r = (phase == 5) ? 2 : $urandom_range(0, 3);
			if (r == 1) begin
				wide = {$urandom(), $urandom()};
				t = wide[TW-1:0];
			end else if (r == 2) begin
				t = '1;
				t = t - $urandom_range(0, 8 * scale + 64);
			end

			for (k = 0; k < PHASE_ITEMS; k++) begin
				if ((phase == 3 && k == 15) || $urandom_range(0, 39) == 0) drain_results();
				// mostly well-formed frame/wake pairs, some out of order
				if ($urandom_range(0, 9) != 0) c = wake_owed ? CMD_WAKE : CMD_FRAME;
				else c = $urandom_range(0, 1);
				r = $urandom_range(0, 19);
				if (c == CMD_WAKE) begin
					if (wake_owed) t = t + wake_wait;
					if (r < 12) t = t + $urandom_range(0, scale / 32 + 3);
					else if (r < 16) t = t - $urandom_range(0, scale / 4 + 3);
					else if (r < 19) t = t + $urandom_range(0, 2 * scale);
					else begin
						wide = {$urandom(), $urandom()};
						t = wide[TW-1:0];
					end
				end else begin
					if (r < 9) t = t + $urandom_range(0, scale);
					else if (r < 14) t = t + scale + $urandom_range(0, scale / 16 + 2);
					else if (r < 18) t = t + $urandom_range(scale, 3 * scale);
					else if (r < 19) t = t - $urandom_range(0, scale);
					else begin
						wide = {$urandom(), $urandom()};
						t = wide[TW-1:0];
					end
				end
				send_item(c, t);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("sent %0d frame and wake beats with %0d register writes", items_sent,
			writes_done);
		$display("compared %0d results, %0d slow frames and %0d out-of-order beats among them",
			checked_count, slow_count, error_count);
		if (fail_count == 0 && results_owed == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
